// ===== hw/rtl/box_select_face_tally_macros.svh =====
// ----------------------------------------------------------------------------
// box select face tally - assertion macros
// property wrappers on clk with the synchronous reset masked out
// ----------------------------------------------------------------------------
`ifndef BOX_SELECT_FACE_TALLY_MACROS_SVH
`define BOX_SELECT_FACE_TALLY_MACROS_SVH

// same-cycle implication
`define BSFT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BSFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bsft_pkg.sv =====
// ----------------------------------------------------------------------------
// bsft_pkg
// shared types, codes and helpers of the box select face tally block
// ----------------------------------------------------------------------------
`default_nettype none

package bsft_pkg;

  localparam int COORD_BITS   = 24;
  localparam int COUNT_BITS   = 16;
  localparam int TOTAL_BITS   = 32;
  localparam int FACE_BITS    = 10;
  localparam int VAL_BITS     = COORD_BITS + 1;
  localparam int PROD_BITS    = 2 * VAL_BITS;
  localparam int CFG_IDX_BITS = 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [VAL_BITS-1:0]   val_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic [COUNT_BITS-1:0]        count_t;
  typedef logic [TOTAL_BITS-1:0]        total_t;

  // triangle classes
  localparam logic [1:0] CLS_BEHIND  = 2'd0;
  localparam logic [1:0] CLS_OUTSIDE = 2'd1;
  localparam logic [1:0] CLS_TOUCH   = 2'd2;
  localparam logic [1:0] CLS_INSIDE  = 2'd3;

  // opcodes
  localparam logic OP_CLASSIFY = 1'b0;
  localparam logic OP_READ     = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_MIN_X   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_MIN_Y   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_MAX_X   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_MAX_Y   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SELECT_MODE = 3'd4;

  typedef struct packed {
    logic                 opcode;
    logic [FACE_BITS-1:0] face_id;
    coord_t               corner_a_x;
    coord_t               corner_a_y;
    coord_t               corner_b_x;
    coord_t               corner_b_y;
    coord_t               corner_c_x;
    coord_t               corner_c_y;
    logic                 all_in_front;
  } in_item_t;

  typedef struct packed {
    logic [1:0] tri_class;
    logic       face_selected;
    count_t     face_triangle_count;
    count_t     face_inside_count;
    count_t     face_touch_count;
    total_t     total_tested;
    total_t     total_behind;
  } out_item_t;

  typedef struct packed {
    count_t tris;
    count_t inner;
    count_t touch;
  } face_entry_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t max_x;
    coord_t max_y;
  } box_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    coord_t cx;
    coord_t cy;
  } corners_t;

  typedef struct packed {
    logic done;
    logic lt;
    logic gt;
  } pcmp_res_t;

  typedef struct packed {
    logic       done;
    logic [1:0] tri_class;
  } geom_res_t;

  function automatic count_t sat_inc(input count_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic total_t sat_total(input total_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bsft_ram.sv =====
// ----------------------------------------------------------------------------
// bsft_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module bsft_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hw/rtl/bsft_pcmp.sv =====
// ----------------------------------------------------------------------------
// bsft_pcmp
// shared exact product compare: sign of a*b - c*d on one multiplier
// ----------------------------------------------------------------------------
`default_nettype none

module bsft_pcmp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  bsft_pkg::val_t      a,
  input  bsft_pkg::val_t      b,
  input  bsft_pkg::val_t      c,
  input  bsft_pkg::val_t      d,
  output bsft_pkg::pcmp_res_t res
);

  import bsft_pkg::*;

  typedef enum logic [3:0] {
    P_IDLE   = 4'b0001,
    P_MUL_AB = 4'b0010,
    P_MUL_CD = 4'b0100,
    P_DONE   = 4'b1000
  } pstate_t;

  pstate_t state_r;
  val_t    a_r, b_r, c_r, d_r;
  prod_t   x_r, y_r;
  val_t    mul_l, mul_r;
  prod_t   prod;

  assign mul_l = (state_r == P_MUL_AB) ? a_r : c_r;
  assign mul_r = (state_r == P_MUL_AB) ? b_r : d_r;
  assign prod  = mul_l * mul_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= P_IDLE;
    end else begin
      unique case (state_r)
        P_IDLE:   if (start) state_r <= P_MUL_AB;
        P_MUL_AB: state_r <= P_MUL_CD;
        P_MUL_CD: state_r <= P_DONE;
        P_DONE:   state_r <= P_IDLE;
        default:  state_r <= P_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == P_IDLE && start) begin
      a_r <= a;
      b_r <= b;
      c_r <= c;
      d_r <= d;
    end
    if (state_r == P_MUL_AB) x_r <= prod;
    if (state_r == P_MUL_CD) y_r <= prod;
  end

  assign res.done = (state_r == P_DONE);
  assign res.lt   = (x_r < y_r);
  assign res.gt   = (x_r > y_r);

endmodule

`default_nettype wire

// ===== hw/rtl/bsft_geom.sv =====
// ----------------------------------------------------------------------------
// bsft_geom
// triangle against box sequencer: corner containment, edge clipping and
// box corner crossing test; the clipping and crossing compares go through the
// shared product unit
`default_nettype none

module bsft_geom (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  bsft_pkg::corners_t  corners,
  input  bsft_pkg::box_t      box,
  output bsft_pkg::geom_res_t res
);

  import bsft_pkg::*;

  typedef enum logic [9:0] {
    G_IDLE    = 10'b00_0000_0001,
    G_CORNER  = 10'b00_0000_0010,
    G_LB_PQ   = 10'b00_0000_0100,
    G_LB_NORM = 10'b00_0000_1000,
    G_LB_CMP1 = 10'b00_0001_0000,
    G_LB_CMP2 = 10'b00_0010_0000,
    G_PT_PREP = 10'b00_0100_0000,
    G_PT_NORM = 10'b00_1000_0000,
    G_PT_CMP  = 10'b01_0000_0000,
    G_DONE    = 10'b10_0000_0000
  } gstate_t;

  gstate_t    state_r;
  logic [1:0] k_r, i_r, cnt_r;
  val_t       n0_r, d0_r, n1_r, d1_r;
  val_t       p_r, q_r, rn_r, rd_r;
  logic       neg_r;
  val_t       pa_r, pb_r, pc_r, pd_r;
  logic       cond_r, inside_r, issued_r;
  logic [1:0] cls_r;

  coord_t     xs [3];
  coord_t     ys [3];

  assign xs[0] = corners.ax;
  assign ys[0] = corners.ay;
  assign xs[1] = corners.bx;
  assign ys[1] = corners.by;
  assign xs[2] = corners.cx;
  assign ys[2] = corners.cy;

  // corner containment, one corner a cycle
  logic corner_in;
  assign corner_in = (box.min_x <= xs[k_r]) && (xs[k_r] <= box.max_x) &&
                     (box.min_y <= ys[k_r]) && (ys[k_r] <= box.max_y);

  // clipping slab terms for edge k -> k+1, slab i
  logic [1:0] kb;
  val_t       ua, ub, lo, hi, pq_p, pq_q;
  assign kb   = (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
  assign ua   = VAL_BITS'(i_r[1] ? ys[k_r] : xs[k_r]);
  assign ub   = VAL_BITS'(i_r[1] ? ys[kb] : xs[kb]);
  assign lo   = VAL_BITS'(i_r[1] ? box.min_y : box.min_x);
  assign hi   = VAL_BITS'(i_r[1] ? box.max_y : box.max_x);
  assign pq_p = i_r[0] ? (ub - ua) : (ua - ub);
  assign pq_q = i_r[0] ? (hi - ua) : (ua - lo);

  // crossing terms for edge j -> i against the box min corner
  logic [1:0] jb;
  val_t       xi, yi, xj, yj, px, py;
  assign jb = (i_r == 2'd0) ? 2'd2 : i_r - 2'd1;
  assign xi = VAL_BITS'(xs[i_r]);
  assign yi = VAL_BITS'(ys[i_r]);
  assign xj = VAL_BITS'(xs[jb]);
  assign yj = VAL_BITS'(ys[jb]);
  assign px = VAL_BITS'(box.min_x);
  assign py = VAL_BITS'(box.min_y);

  // product unit hookup
  logic      pc_start, sel_lo;
  val_t      pc_a, pc_b, pc_c, pc_d;
  pcmp_res_t pc_res;

  assign pc_start = ((state_r == G_LB_CMP1) || (state_r == G_LB_CMP2) ||
                     (state_r == G_PT_CMP)) && !issued_r;
  assign sel_lo   = (state_r == G_LB_CMP1) ? !neg_r : neg_r;

  always_comb begin
    if (state_r == G_PT_CMP) begin
      pc_a = pa_r;
      pc_b = pb_r;
      pc_c = pc_r;
      pc_d = pd_r;
    end else begin
      pc_a = rn_r;
      pc_b = sel_lo ? d0_r : d1_r;
      pc_c = sel_lo ? n0_r : n1_r;
      pc_d = rd_r;
    end
  end

  bsft_pcmp u_pcmp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (pc_start),
    .a     (pc_a),
    .b     (pc_b),
    .c     (pc_c),
    .d     (pc_d),
    .res   (pc_res)
  );

  logic pc_back, edge_fail, step_pass, pt_adv, pt_in;
  assign pc_back   = issued_r && pc_res.done;
  assign edge_fail = ((state_r == G_LB_NORM) && (p_r == '0) && q_r[VAL_BITS-1]) ||
                     ((state_r == G_LB_CMP1) && pc_back &&
                      (neg_r ? pc_res.gt : pc_res.lt));
  assign step_pass = ((state_r == G_LB_NORM) && (p_r == '0) && !q_r[VAL_BITS-1]) ||
                     ((state_r == G_LB_CMP2) && pc_back);
  assign pt_adv    = ((state_r == G_PT_NORM) && !cond_r) ||
                     ((state_r == G_PT_CMP) && pc_back);
  assign pt_in     = inside_r ^ ((state_r == G_PT_CMP) && pc_res.lt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= G_IDLE;
      issued_r <= 1'b0;
    end else begin
      if (pc_res.done) issued_r <= 1'b0;
      else if (pc_start) issued_r <= 1'b1;

      unique case (state_r)
        G_IDLE: begin
          if (start) begin
            k_r     <= 2'd0;
            cnt_r   <= 2'd0;
            state_r <= G_CORNER;
          end
        end
        G_CORNER: begin
          if (k_r == 2'd2) begin
            if (cnt_r == 2'd2 && corner_in) begin
              cls_r   <= CLS_INSIDE;
              state_r <= G_DONE;
            end else if (cnt_r != 2'd0 || corner_in) begin
              cls_r   <= CLS_TOUCH;
              state_r <= G_DONE;
            end else begin
              k_r     <= 2'd0;
              i_r     <= 2'd0;
              n0_r    <= val_t'(0);
              d0_r    <= val_t'(1);
              n1_r    <= val_t'(1);
              d1_r    <= val_t'(1);
              state_r <= G_LB_PQ;
            end
          end else begin
            k_r   <= k_r + 2'd1;
            cnt_r <= cnt_r + {1'b0, corner_in};
          end
        end
        G_LB_PQ: begin
          p_r     <= pq_p;
          q_r     <= pq_q;
          state_r <= G_LB_NORM;
        end
        G_LB_NORM: begin
          if (p_r != '0) begin
            neg_r   <= p_r[VAL_BITS-1];
            rn_r    <= p_r[VAL_BITS-1] ? -q_r : q_r;
            rd_r    <= p_r[VAL_BITS-1] ? -p_r : p_r;
            state_r <= G_LB_CMP1;
          end
        end
        G_LB_CMP1: begin
          if (pc_back && !edge_fail) state_r <= G_LB_CMP2;
        end
        G_LB_CMP2: begin
          // tighten the entering or leaving bound
          if (pc_back) begin
            if (neg_r && pc_res.gt) begin
              n0_r <= rn_r;
              d0_r <= rd_r;
            end else if (!neg_r && pc_res.lt) begin
              n1_r <= rn_r;
              d1_r <= rd_r;
            end
          end
        end
        G_PT_PREP: begin
          cond_r  <= (yi > py) != (yj > py);
          pa_r    <= px - xi;
          pb_r    <= yj - yi;
          pc_r    <= py - yi;
          pd_r    <= xj - xi;
          state_r <= G_PT_NORM;
        end
        G_PT_NORM: begin
          if (cond_r) begin
            if (pb_r[VAL_BITS-1]) begin
              pb_r <= -pb_r;
              pc_r <= -pc_r;
            end
            state_r <= G_PT_CMP;
          end
        end
        G_PT_CMP: begin
        end
        G_DONE: state_r <= G_IDLE;
        default: state_r <= G_IDLE;
      endcase

      if (edge_fail) begin
        i_r <= 2'd0;
        if (k_r == 2'd2) begin
          inside_r <= 1'b0;
          state_r  <= G_PT_PREP;
        end else begin
          k_r     <= k_r + 2'd1;
          n0_r    <= val_t'(0);
          d0_r    <= val_t'(1);
          n1_r    <= val_t'(1);
          d1_r    <= val_t'(1);
          state_r <= G_LB_PQ;
        end
      end

      if (step_pass) begin
        if (i_r == 2'd3) begin
          cls_r   <= CLS_TOUCH;
          state_r <= G_DONE;
        end else begin
          i_r     <= i_r + 2'd1;
          state_r <= G_LB_PQ;
        end
      end

      if (pt_adv) begin
        inside_r <= pt_in;
        if (i_r == 2'd2) begin
          cls_r   <= pt_in ? CLS_TOUCH : CLS_OUTSIDE;
          state_r <= G_DONE;
        end else begin
          i_r     <= i_r + 2'd1;
          state_r <= G_PT_PREP;
        end
      end
    end
  end

  assign res.done      = (state_r == G_DONE);
  assign res.tri_class = cls_r;

endmodule

`default_nettype wire

// ===== hw/rtl/box_select_face_tally.sv =====
// ----------------------------------------------------------------------------
// box_select_face_tally
// Classifies one screen-space triangle per start beat against the selection
// box and keeps per-face tallies; a read beat returns a face's decision and
// counts and clears it. After reset the block sweeps the face store with busy
// high. A read beat or a behind-the-eye triangle goes from the read state
// straight to the execute state and finishes; a triangle in front of the eye
// also waits there for the geometry sequencer, slowest when it needs the edge
// and crossing tests, as the single multiplier does every exact compare as two
// products in turn. busy is low again in the cycle the result strobe is shown,
// so the next start beat may be taken then. The result is on out_data for one
// cycle with out_valid and cannot be held off.
// ----------------------------------------------------------------------------
`default_nettype none
`include "box_select_face_tally_macros.svh"

module box_select_face_tally #(
  parameter int FACE_SLOTS = 1024
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     start,
  output logic                                     busy,
  input  bsft_pkg::in_item_t                       in_data,
  output logic                                     out_valid,
  output bsft_pkg::out_item_t                      out_data,
  input  logic                                     cfg_we,
  input  logic [bsft_pkg::CFG_IDX_BITS-1:0]        cfg_index,
  input  logic [bsft_pkg::COORD_BITS-1:0]          cfg_wdata
);

  import bsft_pkg::*;

  localparam int ADDR_BITS = $clog2(FACE_SLOTS);

  typedef enum logic [3:0] {
    T_CLEAR = 4'b0001,
    T_IDLE  = 4'b0010,
    T_READ  = 4'b0100,
    T_EXEC  = 4'b1000
  } tstate_t;

  tstate_t                state_r;
  logic [ADDR_BITS-1:0]   clr_addr_r;
  in_item_t               item_r;
  box_t                   box_r;
  logic                   mode_r;
  total_t                 tested_r, behind_r;
  logic                   out_valid_r;
  out_item_t              out_r;

  // face store
  logic                   slot_ok;
  logic [ADDR_BITS-1:0]   slot_addr;
  logic                   ram_we;
  logic [ADDR_BITS-1:0]   ram_waddr;
  face_entry_t            ram_wdata, cur, upd;

  assign slot_ok   = 32'(item_r.face_id) < 32'(FACE_SLOTS);
  assign slot_addr = ADDR_BITS'(item_r.face_id);

  bsft_ram #(
    .WIDTH ($bits(face_entry_t)),
    .DEPTH (FACE_SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (slot_addr),
    .rdata (cur)
  );

  // geometry
  logic      is_classify, need_geom, go;
  corners_t  corners;
  geom_res_t geom_res;

  assign is_classify = (item_r.opcode == OP_CLASSIFY);
  assign need_geom   = is_classify && item_r.all_in_front;
  assign corners     = '{ax: item_r.corner_a_x, ay: item_r.corner_a_y,
                         bx: item_r.corner_b_x, by: item_r.corner_b_y,
                         cx: item_r.corner_c_x, cy: item_r.corner_c_y};

  bsft_geom u_geom (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   ((state_r == T_READ) && need_geom),
    .corners (corners),
    .box     (box_r),
    .res     (geom_res)
  );

  assign go = (state_r == T_EXEC) && (!need_geom || geom_res.done);

  // tally update and result
  logic [1:0] cls;
  logic       sel;
  total_t     tested_nxt, behind_nxt;
  out_item_t  res_nxt;

  assign cls = need_geom ? geom_res.tri_class : CLS_BEHIND;

  always_comb begin
    if (is_classify) begin
      upd.tris   = sat_inc(cur.tris);
      upd.inner  = (cls == CLS_INSIDE) ? sat_inc(cur.inner) : cur.inner;
      upd.touch  = (cls == CLS_INSIDE || cls == CLS_TOUCH) ? sat_inc(cur.touch)
                                                           : cur.touch;
    end else begin
      upd = '0;
    end
  end

  assign sel = slot_ok && (item_r.face_id != '0) && (cur.tris != '0) &&
               (mode_r ? (cur.touch != '0) : (cur.inner == cur.tris));

  assign tested_nxt = is_classify ? sat_total(tested_r) : tested_r;
  assign behind_nxt = (is_classify && !item_r.all_in_front) ? sat_total(behind_r)
                                                            : behind_r;

  always_comb begin
    res_nxt              = '0;
    res_nxt.total_tested = tested_nxt;
    res_nxt.total_behind = behind_nxt;
    if (is_classify) begin
      res_nxt.tri_class = cls;
    end else if (slot_ok) begin
      res_nxt.face_selected       = sel;
      res_nxt.face_triangle_count = cur.tris;
      res_nxt.face_inside_count   = cur.inner;
      res_nxt.face_touch_count    = cur.touch;
    end
  end

  assign ram_we    = (state_r == T_CLEAR) || (go && slot_ok);
  assign ram_waddr = (state_r == T_CLEAR) ? clr_addr_r : slot_addr;
  assign ram_wdata = (state_r == T_CLEAR) ? face_entry_t'('0) : upd;

  assign busy = (state_r != T_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      tested_r    <= '0;
      behind_r    <= '0;
    end else begin
      out_valid_r <= go;
      unique case (state_r)
        T_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == ADDR_BITS'(FACE_SLOTS - 1)) state_r <= T_IDLE;
        end
        T_IDLE:  if (start) state_r <= T_READ;
        T_READ:  state_r <= T_EXEC;
        T_EXEC: begin
          if (go) begin
            tested_r    <= tested_nxt;
            behind_r    <= behind_nxt;
            state_r     <= T_IDLE;
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == T_IDLE && start) item_r <= in_data;
    if (go) out_r <= res_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r  <= '0;
      mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BOX_MIN_X:   box_r.min_x <= cfg_wdata;
        CFG_BOX_MIN_Y:   box_r.min_y <= cfg_wdata;
        CFG_BOX_MAX_X:   box_r.max_x <= cfg_wdata;
        CFG_BOX_MAX_Y:   box_r.max_y <= cfg_wdata;
        CFG_SELECT_MODE: mode_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `BSFT_ASSERT_IMP(a_strobe_after_work, out_valid, $past(busy), "result beat without work")
  `BSFT_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result beat repeated")
  `BSFT_ASSERT_IMP(a_select_needs_tris, out_valid && out_data.face_selected, out_data.face_triangle_count != '0 && out_data.tri_class == CLS_BEHIND, "selected face without triangles")
  `BSFT_ASSERT_IMP(a_behind_bounded, out_valid, out_data.total_behind <= out_data.total_tested, "behind total above tested total")

endmodule

`default_nettype wire

// ===== tb/box_select_face_tally_tb.sv =====
// ----------------------------------------------------------------------------
// box_select_face_tally_tb
// Drives classify and read beats into the box select face tally block. A
// scoreboard predicts every result from its own copy of the box registers,
// the face tallies and the totals. Each result strobe is then checked field
// by field. A short directed part is followed by random phases, each with its
// own box and selection mode.
// ----------------------------------------------------------------------------
`default_nettype none

module box_select_face_tally_tb;
  import bsft_pkg::*;

  localparam int  NUM_FACES  = 1024;
  localparam int  CLK_HALF   = 6;
  localparam longint C_MIN   = -(longint'(1) << (COORD_BITS - 1));
  localparam longint C_MAX   = (longint'(1) << (COORD_BITS - 1)) - 1;

  class face_tally_scoreboard;
    face_entry_t tallies[NUM_FACES];
    total_t      tested;
    total_t      behind;
    longint      bx0, by0, bx1, by1;
    bit          crossing;
    out_item_t   pending_results[$];
    int          errors;
    int          class_seen[4];
    int          reads;
    int          selected;

    function new();
      foreach (tallies[i]) tallies[i] = '0;
      tested = '0;
      behind = '0;
      bx0 = 0; by0 = 0; bx1 = 0; by1 = 0;
      crossing = 1'b0;
      errors = 0;
      reads = 0;
      selected = 0;
      foreach (class_seen[i]) class_seen[i] = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, coord_t val);
      case (idx)
        CFG_BOX_MIN_X:   bx0 = val;
        CFG_BOX_MIN_Y:   by0 = val;
        CFG_BOX_MAX_X:   bx1 = val;
        CFG_BOX_MAX_Y:   by1 = val;
        CFG_SELECT_MODE: crossing = val[0];
        default: ;
      endcase
    endfunction

    function count_t bump(count_t v);
      return (v == {COUNT_BITS{1'b1}}) ? v : count_t'(v + 1);
    endfunction

    function total_t bump_total(total_t v);
      return (v == {TOTAL_BITS{1'b1}}) ? v : total_t'(v + 1);
    endfunction

    function bit contains(longint x, longint y);
      return bx0 <= x && x <= bx1 && by0 <= y && y <= by1;
    endfunction

    // parametric clip of one edge, entry and exit kept as fractions n/d
    function bit edge_hits(longint ax, longint ay, longint qx, longint qy);
      longint n0, d0, n1, d1, rn, rd;
      longint p[4];
      longint q[4];
      n0 = 0; d0 = 1; n1 = 1; d1 = 1;
      p[0] = ax - qx; p[1] = qx - ax; p[2] = ay - qy; p[3] = qy - ay;
      q[0] = ax - bx0; q[1] = bx1 - ax; q[2] = ay - by0; q[3] = by1 - ay;
      for (int i = 0; i < 4; i++) begin
        if (p[i] == 0) begin
          if (q[i] < 0) return 1'b0;
        end else if (p[i] < 0) begin
          rn = -q[i]; rd = -p[i];
          if (rn * d1 > n1 * rd) return 1'b0;
          if (rn * d0 > n0 * rd) begin
            n0 = rn; d0 = rd;
          end
        end else begin
          rn = q[i]; rd = p[i];
          if (rn * d0 < n0 * rd) return 1'b0;
          if (rn * d1 < n1 * rd) begin
            n1 = rn; d1 = rd;
          end
        end
      end
      return 1'b1;
    endfunction

    // even-odd rule for the box's min corner
    function bit corner_in_tri(longint xs[3], longint ys[3]);
      bit     odd;
      int     j;
      longint dn, num;
      odd = 1'b0;
      j = 2;
      for (int i = 0; i < 3; i++) begin
        if ((ys[i] > by0) != (ys[j] > by0)) begin
          dn = ys[j] - ys[i];
          num = by0 - ys[i];
          if (dn < 0) begin
            dn = -dn; num = -num;
          end
          if ((bx0 - xs[i]) * dn < num * (xs[j] - xs[i])) odd = !odd;
        end
        j = i;
      end
      return odd;
    endfunction

    function void note_beat(in_item_t it);
      out_item_t   res;
      longint      xs[3], ys[3];
      int          n_in;
      bit          hit;
      face_entry_t ent;
      res = '0;
      if (it.opcode == OP_CLASSIFY) begin
        tested = bump_total(tested);
        tallies[it.face_id].tris = bump(tallies[it.face_id].tris);
        if (!it.all_in_front) begin
          behind = bump_total(behind);
          res.tri_class = CLS_BEHIND;
        end else begin
          xs[0] = it.corner_a_x; ys[0] = it.corner_a_y;
          xs[1] = it.corner_b_x; ys[1] = it.corner_b_y;
          xs[2] = it.corner_c_x; ys[2] = it.corner_c_y;
          n_in = 0;
          for (int k = 0; k < 3; k++) if (contains(xs[k], ys[k])) n_in++;
          if (n_in == 3) res.tri_class = CLS_INSIDE;
          else if (n_in > 0) res.tri_class = CLS_TOUCH;
          else begin
            hit = 1'b0;
            for (int k = 0; k < 3 && !hit; k++)
              hit = edge_hits(xs[k], ys[k], xs[(k+1)%3], ys[(k+1)%3]);
            if (!hit) hit = corner_in_tri(xs, ys);
            res.tri_class = hit ? CLS_TOUCH : CLS_OUTSIDE;
          end
          if (res.tri_class == CLS_INSIDE)
            tallies[it.face_id].inner = bump(tallies[it.face_id].inner);
          if (res.tri_class == CLS_INSIDE || res.tri_class == CLS_TOUCH)
            tallies[it.face_id].touch = bump(tallies[it.face_id].touch);
        end
        class_seen[res.tri_class]++;
      end else begin
        ent = tallies[it.face_id];
        res.face_triangle_count = ent.tris;
        res.face_inside_count   = ent.inner;
        res.face_touch_count    = ent.touch;
        if (it.face_id != 0 && ent.tris != 0)
          res.face_selected = crossing ? (ent.touch != 0) : (ent.inner == ent.tris);
        tallies[it.face_id] = '0;
        reads++;
        if (res.face_selected) selected++;
      end
      res.total_tested = tested;
      res.total_behind = behind;
      pending_results = {pending_results, res};
    endfunction

    function void field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (pending_results.size() == 0) begin
        $error("result strobe with nothing outstanding");
        errors++;
        return;
      end
      exp_r = pending_results.pop_front();
      field("tri_class", exp_r.tri_class, got.tri_class);
      field("face_selected", exp_r.face_selected, got.face_selected);
      field("face_triangle_count", exp_r.face_triangle_count, got.face_triangle_count);
      field("face_inside_count", exp_r.face_inside_count, got.face_inside_count);
      field("face_touch_count", exp_r.face_touch_count, got.face_touch_count);
      field("total_tested", exp_r.total_tested, got.total_tested);
      field("total_behind", exp_r.total_behind, got.total_behind);
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  in_item_t                in_data;
  logic                    out_valid;
  out_item_t               out_data;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [COORD_BITS-1:0]   cfg_wdata;

  face_tally_scoreboard sb;

  box_select_face_tally #(.FACE_SLOTS(NUM_FACES)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_data);
  end

  function automatic coord_t clamp(longint v);
    if (v < C_MIN) return coord_t'(C_MIN);
    if (v > C_MAX) return coord_t'(C_MAX);
    return coord_t'(v);
  endfunction

  function automatic in_item_t tri_beat(int face, longint ax, longint ay, longint qx,
                                        longint qy, longint cx, longint cy, bit front = 1);
    in_item_t it;
    it.opcode = OP_CLASSIFY;
    it.face_id = face[FACE_BITS-1:0];
    it.corner_a_x = clamp(ax); it.corner_a_y = clamp(ay);
    it.corner_b_x = clamp(qx); it.corner_b_y = clamp(qy);
    it.corner_c_x = clamp(cx); it.corner_c_y = clamp(cy);
    it.all_in_front = front;
    return it;
  endfunction

  function automatic in_item_t read_beat(int face);
    in_item_t it;
    it = '0;
    it.opcode = OP_READ;
    it.face_id = face[FACE_BITS-1:0];
    it.corner_a_x = coord_t'($urandom);
    it.all_in_front = $urandom_range(0, 1);
    return it;
  endfunction

  // start stays high straight into the next beat when there is no gap
  task automatic send(in_item_t it);
    @(negedge clk);
    in_data = it;
    start = 1'b1;
    do @(posedge clk); while (busy);
    sb.note_beat(it);
  endtask

  task automatic pause(int cycles);
    @(negedge clk);
    start = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return;
    if (r < 90) pause($urandom_range(0, 3));
    else pause($urandom_range(10, 40));
  endtask

  task automatic drain();
    pause(0);
    while (sb.pending_results.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, longint val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = clamp(val);
    sb.set_reg(idx, clamp(val));
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_box(longint x0, longint y0, longint x1, longint y1, bit mode);
    drain();
    write_reg(CFG_BOX_MIN_X, x0);
    write_reg(CFG_BOX_MIN_Y, y0);
    write_reg(CFG_BOX_MAX_X, x1);
    write_reg(CFG_BOX_MAX_Y, y1);
    write_reg(CFG_SELECT_MODE, mode);
  endtask

  function automatic longint near_box(longint lo, longint hi);
    longint a, b, span;
    a = (lo < hi) ? lo : hi;
    b = (lo < hi) ? hi : lo;
    span = (b - a) / 2 + 512;
    if ($urandom_range(0, 6) == 0) return longint'(coord_t'($urandom));
    return a - span + longint'($urandom_range(0, 32'(b - a + 2 * span)));
  endfunction

  function automatic in_item_t random_beat();
    int face;
    face = ($urandom_range(0, 4) == 0) ? $urandom_range(0, NUM_FACES - 1)
                                       : $urandom_range(0, 7);
    if ($urandom_range(0, 99) < 22) return read_beat(face);
    return tri_beat(face, near_box(sb.bx0, sb.bx1), near_box(sb.by0, sb.by1),
                    near_box(sb.bx0, sb.bx1), near_box(sb.by0, sb.by1),
                    near_box(sb.bx0, sb.bx1), near_box(sb.by0, sb.by1),
                    $urandom_range(0, 9) != 0);
  endfunction

  initial begin
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // directed: box of +-10 pixels, window mode
    set_box(-2560, -2560, 2560, 2560, 1'b0);
    send(tri_beat(1, 0, 0, 256, 0, 0, 256));
    send(tri_beat(1, 0, 0, 10000, 0, 0, 10000));
    send(tri_beat(2, -5000, 0, 5000, 0, 5000, 5000));
    send(tri_beat(3, -100000, -100000, 100000, -100000, 0, 100000));
    send(tri_beat(3, 5000, 5000, 6000, 5000, 5000, 6000));
    send(tri_beat(4, 0, 0, 0, 0, 0, 0, 1'b0));
    send(tri_beat(5, 0, 0, 0, 0, 0, 0));
    send(tri_beat(5, -5000, 0, 5000, 0, -5000, 0));
    send(tri_beat(NUM_FACES - 1, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX));
    send(tri_beat(6, 2560, 2560, 2560, -2560, -2560, 2560));
    send(tri_beat(0, 0, 0, 1, 1, 2, 0));
    send(read_beat(0));
    send(read_beat(6));
    for (int f = 1; f <= 5; f++) send(read_beat(f));
    send(read_beat(NUM_FACES - 1));
    send(read_beat(7));
    set_box(-2560, -2560, 2560, 2560, 1'b1);
    send(tri_beat(2, -5000, 0, 5000, 0, 5000, 5000));
    send(tri_beat(3, 5000, 5000, 6000, 5000, 5000, 6000));
    send(read_beat(2));
    send(read_beat(3));

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_box(C_MIN, C_MIN, C_MAX, C_MAX, 1'b1);
        1: set_box(4000, 3000, -4000, -3000, 1'b0);
        2: set_box(1280, 1280, 1280, 1280, 1'b1);
        3: set_box(C_MAX - 8000, C_MIN, C_MAX, C_MIN + 8000, 1'b0);
        default: begin
          longint x0, y0;
          x0 = longint'($urandom_range(0, 400000)) - 200000;
          y0 = longint'($urandom_range(0, 400000)) - 200000;
          set_box(x0, y0, x0 + $urandom_range(0, 60000), y0 + $urandom_range(0, 60000),
                  $urandom_range(0, 1));
        end
      endcase
      for (int n = 0; n < 100; n++) begin
        send(random_beat());
        random_gap();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("classes behind/outside/touch/inside: %0d/%0d/%0d/%0d",
             sb.class_seen[0], sb.class_seen[1], sb.class_seen[2], sb.class_seen[3]);
    $display("face reads: %0d, selected: %0d, mismatches: %0d",
             sb.reads, sb.selected, sb.errors);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(2 * CLK_HALF * 1500000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
